// ===== hw/rtl/alle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int LINK_W     = SLOT_W + 1;
	localparam int CFG_W      = 9;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LINK_W-1:0] link_t;

	// null link: one past the last slot
	localparam link_t NIL = LINK_W'(CAPACITY);

	typedef enum logic [2:0] {
		MODE_APPEND     = 3'd0,
		MODE_INS_BEFORE = 3'd1,
		MODE_INS_AFTER  = 3'd2,
		MODE_REMOVE     = 3'd3,
		MODE_READ       = 3'd4,
		MODE_NEXT       = 3'd5,
		MODE_PREV       = 3'd6,
		MODE_NOP        = 3'd7
	} mode_e;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NOT_USED = 2'd2
	} status_e;

	typedef struct packed {
		logic [2:0]            mode;
		slot_t                 position;
		logic [DATA_WIDTH-1:0] item_data;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		slot_t                 result_slot;
		logic                  result_null;
		logic [DATA_WIDTH-1:0] result_data;
		link_t                 list_length;
		slot_t                 head_slot;
		slot_t                 tail_slot;
		logic                  list_empty;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic step1;
		logic step2;
		logic step3;
		logic load_rsp;
	} ctrl_cmd_t;

	typedef struct packed {
		logic write_op;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/alle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alle_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	input  wire                  cfg_valid,
	input  wire                  rsp_ready,
	input  alle_pkg::dp_sts_t    sts,
	output logic                 req_ready,
	output logic                 cfg_ready,
	output logic                 rsp_valid,
	output alle_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_W1   = 5'b00010,
		S_W2   = 5'b00100,
		S_W3   = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cfg_ready    = (state_q == S_IDLE);
		req_ready    = (state_q == S_IDLE) && !cfg_valid;
		cmd.accept   = req_valid && req_ready;
		cmd.cfg_wr   = cfg_valid && cfg_ready;
		cmd.step1    = (state_q == S_W1);
		cmd.step2    = (state_q == S_W2);
		cmd.step3    = (state_q == S_W3);
		cmd.load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					state_d = sts.write_op ? S_W1 : S_DONE;
				end
			end
			S_W1: state_d = S_W2;
			S_W2: state_d = S_W3;
			S_W3: state_d = S_DONE;
			S_DONE: begin
				if (cmd.load_rsp) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// write steps always run as a full burst
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W1) |=> (state_q == S_W2) ##1 (state_q == S_W3) ##1 (state_q == S_DONE))
		else $error("write burst broken");

	// a finished result waits while the output slot is still occupied
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp_ready) |=> (state_q == S_DONE))
		else $error("result overwrote pending response");

	// response valid only rises out of the done state
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response without completed operation");

	// config and request never taken together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.cfg_wr))
		else $error("config and request accepted together");

endmodule

`default_nettype wire

// ===== hw/rtl/alle_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alle_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  alle_pkg::ctrl_cmd_t              cmd,
	input  alle_pkg::req_t                   req,
	input  wire [alle_pkg::CFG_W-1:0]        cfg_data,
	output alle_pkg::dp_sts_t                sts,
	output alle_pkg::rsp_t                   rsp
);

	function automatic alle_pkg::link_t init_next(input alle_pkg::slot_t idx,
		input alle_pkg::link_t n);
		alle_pkg::link_t nxt;
		nxt = alle_pkg::LINK_W'(idx) + alle_pkg::LINK_W'(1);
		return (nxt < n) ? nxt : alle_pkg::NIL;
	endfunction

	// link stores
	alle_pkg::link_t               next_mem [alle_pkg::CAPACITY];
	alle_pkg::link_t               prev_mem [alle_pkg::CAPACITY];
	logic [alle_pkg::DATA_WIDTH-1:0] data_mem [alle_pkg::CAPACITY];

	// list registers
	alle_pkg::link_t n_q, free_q, head_q, tail_q, count_q;
	logic            used_q [alle_pkg::CAPACITY];
	logic            nvld_q [alle_pkg::CAPACITY];

	// captured request
	alle_pkg::mode_e                 mode_q;
	alle_pkg::slot_t                 pos_q;
	logic [alle_pkg::DATA_WIDTH-1:0] data_q;
	alle_pkg::link_t                 slot_q;
	alle_pkg::status_e               stat_q;

	// read data
	alle_pkg::link_t                 rd_next_p_q, rd_next_f_q, ini_p_q, ini_f_q, rd_prev_p_q;
	logic                            nvld_p_q, nvld_f_q;
	logic [alle_pkg::DATA_WIDTH-1:0] rd_data_p_q;

	alle_pkg::link_t lk_a, lk_b, lk_f, pos_link;
	alle_pkg::mode_e mode_in;
	alle_pkg::status_e stat_in;
	alle_pkg::link_t n_d;

	logic            nx_we, pv_we, dt_we;
	alle_pkg::slot_t nx_wa, pv_wa, dt_wa;
	alle_pkg::link_t nx_wd, pv_wd;
	logic [alle_pkg::DATA_WIDTH-1:0] dt_wd;

	alle_pkg::rsp_t rsp_d, rsp_q;

	assign lk_a     = rd_prev_p_q;
	assign lk_b     = nvld_p_q ? rd_next_p_q : ini_p_q;
	assign lk_f     = nvld_f_q ? rd_next_f_q : ini_f_q;
	assign pos_link = {1'b0, pos_q};

	// request check
	always_comb begin
		mode_in = alle_pkg::mode_e'(req.mode);
		if (mode_in >= alle_pkg::MODE_INS_BEFORE && mode_in <= alle_pkg::MODE_PREV
			&& !used_q[req.position]) begin
			stat_in = alle_pkg::STAT_NOT_USED;
		end else if (mode_in <= alle_pkg::MODE_INS_AFTER && free_q == alle_pkg::NIL) begin
			stat_in = alle_pkg::STAT_FULL;
		end else begin
			stat_in = alle_pkg::STAT_OK;
		end
		sts.write_op = (stat_in == alle_pkg::STAT_OK) && (mode_in <= alle_pkg::MODE_REMOVE);
	end

	always_comb begin
		if (cfg_data == '0) begin
			n_d = alle_pkg::LINK_W'(1);
		end else if (cfg_data > alle_pkg::CFG_W'(alle_pkg::CAPACITY)) begin
			n_d = alle_pkg::LINK_W'(alle_pkg::CAPACITY);
		end else begin
			n_d = alle_pkg::LINK_W'(cfg_data);
		end
	end

	// write port selection per step
	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
		dt_we = 1'b0; dt_wa = '0; dt_wd = '0;
		if (cmd.step1) begin
			unique case (mode_q)
				alle_pkg::MODE_APPEND: begin
					nx_we = 1'b1; nx_wa = slot_q[alle_pkg::SLOT_W-1:0]; nx_wd = alle_pkg::NIL;
					pv_we = 1'b1; pv_wa = slot_q[alle_pkg::SLOT_W-1:0]; pv_wd = tail_q;
					dt_we = 1'b1; dt_wa = slot_q[alle_pkg::SLOT_W-1:0]; dt_wd = data_q;
				end
				alle_pkg::MODE_INS_BEFORE: begin
					nx_we = 1'b1; nx_wa = slot_q[alle_pkg::SLOT_W-1:0]; nx_wd = pos_link;
					pv_we = 1'b1; pv_wa = slot_q[alle_pkg::SLOT_W-1:0]; pv_wd = lk_a;
					dt_we = 1'b1; dt_wa = slot_q[alle_pkg::SLOT_W-1:0]; dt_wd = data_q;
				end
				alle_pkg::MODE_INS_AFTER: begin
					nx_we = 1'b1; nx_wa = slot_q[alle_pkg::SLOT_W-1:0]; nx_wd = lk_b;
					pv_we = 1'b1; pv_wa = slot_q[alle_pkg::SLOT_W-1:0]; pv_wd = pos_link;
					dt_we = 1'b1; dt_wa = slot_q[alle_pkg::SLOT_W-1:0]; dt_wd = data_q;
				end
				alle_pkg::MODE_REMOVE: begin
					// unlink from neighbors
					nx_we = (lk_a != alle_pkg::NIL);
					nx_wa = lk_a[alle_pkg::SLOT_W-1:0];
					nx_wd = lk_b;
					pv_we = (lk_b != alle_pkg::NIL);
					pv_wa = lk_b[alle_pkg::SLOT_W-1:0];
					pv_wd = lk_a;
				end
				default: ;
			endcase
		end else if (cmd.step2) begin
			unique case (mode_q)
				alle_pkg::MODE_APPEND: begin
					nx_we = (tail_q != alle_pkg::NIL);
					nx_wa = tail_q[alle_pkg::SLOT_W-1:0];
					nx_wd = slot_q;
				end
				alle_pkg::MODE_INS_BEFORE: begin
					nx_we = (lk_a != alle_pkg::NIL);
					nx_wa = lk_a[alle_pkg::SLOT_W-1:0];
					nx_wd = slot_q;
					pv_we = 1'b1; pv_wa = pos_q; pv_wd = slot_q;
				end
				alle_pkg::MODE_INS_AFTER: begin
					nx_we = 1'b1; nx_wa = pos_q; nx_wd = slot_q;
					pv_we = (lk_b != alle_pkg::NIL);
					pv_wa = lk_b[alle_pkg::SLOT_W-1:0];
					pv_wd = slot_q;
				end
				alle_pkg::MODE_REMOVE: begin
					nx_we = 1'b1;
					nx_wa = pos_q;
					nx_wd = (free_q == alle_pkg::NIL) ? alle_pkg::NIL : lk_f;
				end
				default: ;
			endcase
		end else if (cmd.step3) begin
			if (mode_q == alle_pkg::MODE_REMOVE && free_q != alle_pkg::NIL) begin
				// freed slot goes right after the free head
				nx_we = 1'b1;
				nx_wa = free_q[alle_pkg::SLOT_W-1:0];
				nx_wd = pos_link;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (cmd.accept) begin
			rd_next_p_q <= next_mem[req.position];
			rd_next_f_q <= next_mem[free_q[alle_pkg::SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (cmd.accept) begin
			rd_prev_p_q <= prev_mem[req.position];
		end
	end

	always_ff @(posedge clk) begin
		if (dt_we) begin
			data_mem[dt_wa] <= dt_wd;
		end
		if (cmd.accept) begin
			rd_data_p_q <= data_mem[req.position];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q   <= mode_in;
			pos_q    <= req.position;
			data_q   <= req.item_data;
			slot_q   <= free_q;
			stat_q   <= stat_in;
			nvld_p_q <= nvld_q[req.position];
			nvld_f_q <= nvld_q[free_q[alle_pkg::SLOT_W-1:0]];
			ini_p_q  <= init_next(req.position, n_q);
			ini_f_q  <= init_next(free_q[alle_pkg::SLOT_W-1:0], n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= alle_pkg::LINK_W'(alle_pkg::CAPACITY);
			free_q  <= '0;
			head_q  <= alle_pkg::NIL;
			tail_q  <= alle_pkg::NIL;
			count_q <= '0;
			for (int i = 0; i < alle_pkg::CAPACITY; i++) begin
				used_q[i] <= 1'b0;
				nvld_q[i] <= 1'b0;
			end
		end else if (cmd.cfg_wr) begin
			n_q     <= n_d;
			free_q  <= '0;
			head_q  <= alle_pkg::NIL;
			tail_q  <= alle_pkg::NIL;
			count_q <= '0;
			for (int i = 0; i < alle_pkg::CAPACITY; i++) begin
				used_q[i] <= 1'b0;
				nvld_q[i] <= 1'b0;
			end
		end else begin
			if (nx_we) begin
				nvld_q[nx_wa] <= 1'b1;
			end
			if (cmd.step3) begin
				unique case (mode_q)
					alle_pkg::MODE_APPEND: begin
						free_q <= lk_f;
						used_q[slot_q[alle_pkg::SLOT_W-1:0]] <= 1'b1;
						count_q <= count_q + alle_pkg::LINK_W'(1);
						if (tail_q == alle_pkg::NIL) begin
							head_q <= slot_q;
						end
						tail_q <= slot_q;
					end
					alle_pkg::MODE_INS_BEFORE: begin
						free_q <= lk_f;
						used_q[slot_q[alle_pkg::SLOT_W-1:0]] <= 1'b1;
						count_q <= count_q + alle_pkg::LINK_W'(1);
						if (lk_a == alle_pkg::NIL) begin
							head_q <= slot_q;
						end
					end
					alle_pkg::MODE_INS_AFTER: begin
						free_q <= lk_f;
						used_q[slot_q[alle_pkg::SLOT_W-1:0]] <= 1'b1;
						count_q <= count_q + alle_pkg::LINK_W'(1);
						if (lk_b == alle_pkg::NIL) begin
							tail_q <= slot_q;
						end
					end
					alle_pkg::MODE_REMOVE: begin
						if (lk_a == alle_pkg::NIL) begin
							head_q <= lk_b;
						end
						if (lk_b == alle_pkg::NIL) begin
							tail_q <= lk_a;
						end
						used_q[pos_q] <= 1'b0;
						if (free_q == alle_pkg::NIL) begin
							free_q <= pos_link;
						end
						count_q <= count_q - alle_pkg::LINK_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	// response: outcome plus snapshot after the update
	always_comb begin
		rsp_d             = '0;
		rsp_d.status      = stat_q;
		rsp_d.list_length = count_q;
		rsp_d.head_slot   = (head_q == alle_pkg::NIL) ? '0 : head_q[alle_pkg::SLOT_W-1:0];
		rsp_d.tail_slot   = (tail_q == alle_pkg::NIL) ? '0 : tail_q[alle_pkg::SLOT_W-1:0];
		rsp_d.list_empty  = (count_q == '0);
		if (stat_q == alle_pkg::STAT_OK) begin
			unique case (mode_q)
				alle_pkg::MODE_APPEND,
				alle_pkg::MODE_INS_BEFORE,
				alle_pkg::MODE_INS_AFTER: rsp_d.result_slot = slot_q[alle_pkg::SLOT_W-1:0];
				alle_pkg::MODE_READ:      rsp_d.result_data = rd_data_p_q;
				alle_pkg::MODE_NEXT: begin
					if (lk_b == alle_pkg::NIL) begin
						rsp_d.result_null = 1'b1;
					end else begin
						rsp_d.result_slot = lk_b[alle_pkg::SLOT_W-1:0];
					end
				end
				alle_pkg::MODE_PREV: begin
					if (lk_a == alle_pkg::NIL) begin
						rsp_d.result_null = 1'b1;
					end else begin
						rsp_d.result_slot = lk_a[alle_pkg::SLOT_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/array_linked_list_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Doubly linked list engine over a 256-slot store with a free-slot chain. Each
// request transaction (append, insert before/after, remove, read, next, previous)
// returns exactly one response transaction with status, result slot or data and
// a snapshot of length, head and tail. Read, next, previous, the unused mode and
// any rejected request go from acceptance straight to the done state, where the
// response is loaded. Append, insert and remove first pass the write states W1,
// W2 and W3. These steps come from the single write port of the next-link memory,
// which needs up to three writes (neighbor, freed slot, free head) per operation.
// A finished result waits in the done state for as long as the output still holds
// an unread response.
// A new request is taken while the previous response still waits at the output.
// The config transaction sets slots_in_use and re-initializes the store at once:
// in-use and link-valid flags clear together, an unwritten next link reads as
// its free-chain default, so there is no clearing pass after reset or config.

module array_linked_list_engine_core (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        req_valid,
	output logic                       req_ready,
	input  alle_pkg::req_t             req,
	output logic                       rsp_valid,
	input  wire                        rsp_ready,
	output alle_pkg::rsp_t             rsp,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [alle_pkg::CFG_W-1:0]  cfg_data
);

	// command and status between controller and datapath
	alle_pkg::ctrl_cmd_t cmd;
	alle_pkg::dp_sts_t   sts;

	// sequencing: accept, three write steps when the list changes, response load
	alle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cfg_valid (cfg_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.req_ready (req_ready),
		.cfg_ready (cfg_ready),
		.rsp_valid (rsp_valid),
		.cmd       (cmd)
	);

	// link/data memories, list pointers and the response register
	alle_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_data (cfg_data),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire
